>>> hw/rtl/rfc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the response
// frame checker. No dependencies; used by every other file of the block.
package rfc_pkg;

  localparam int MAX_PAYLOAD  = 128;
  localparam int MAX_DEVICES  = 64;
  localparam int HEADER_BYTES = 4;
  localparam int CRC_BYTES    = 2;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;  // 0x8005 bit-reversed
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } rfc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_RECEIVING = 3'd1,
    ST_FRAME_OK  = 3'd2,
    ST_ALL_OK    = 3'd3,
    ST_CRC_ERR   = 3'd4,
    ST_TIMEOUT   = 3'd5
  } rfc_status_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [7:0] data_length;
    logic [6:0] num_devices;
  } rfc_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] device_index;
    logic [7:0] byte_index;
    logic [7:0] rx_byte_out;
    logic       is_payload;
  } rfc_result_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/rfc_core.sv
// Receive state and per-item decision logic of the response frame checker.
// Depends on rfc_pkg for types, constants and the CRC byte update.
module rfc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  rfc_pkg::rfc_item_t   item,
  input  logic [15:0]          timeout_ticks,
  output rfc_pkg::rfc_result_t result
);

  logic        receiving_r, receiving_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [5:0]  frame_count_r, frame_count_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [7:0]  exp_payload_r, exp_payload_nxt;
  logic [6:0]  exp_frames_r, exp_frames_nxt;

  logic [15:0] crc_after;
  logic [7:0]  byte_count_inc;
  logic [15:0] tick_inc;
  logic [7:0]  frame_size;
  logic [7:0]  payload_end;
  logic [6:0]  frame_next;
  logic [7:0]  len_clamped;
  logic [6:0]  cnt_clamped;

  assign crc_after      = rfc_pkg::crc_feed(crc_r, item.rx_byte);
  assign byte_count_inc = byte_count_r + 8'd1;
  assign tick_inc       = tick_count_r + 16'd1;
  assign payload_end    = 8'(rfc_pkg::HEADER_BYTES) + exp_payload_r;
  assign frame_size     = payload_end + 8'(rfc_pkg::CRC_BYTES);
  assign frame_next     = {1'b0, frame_count_r} + 7'd1;

  always_comb begin
    if (item.data_length == 8'd0) begin
      len_clamped = 8'd1;
    end else if (item.data_length > 8'(rfc_pkg::MAX_PAYLOAD)) begin
      len_clamped = 8'(rfc_pkg::MAX_PAYLOAD);
    end else begin
      len_clamped = item.data_length;
    end
    if (item.num_devices == 7'd0) begin
      cnt_clamped = 7'd1;
    end else if (item.num_devices > 7'(rfc_pkg::MAX_DEVICES)) begin
      cnt_clamped = 7'(rfc_pkg::MAX_DEVICES);
    end else begin
      cnt_clamped = item.num_devices;
    end
  end

  always_comb begin
    receiving_nxt   = receiving_r;
    crc_nxt         = crc_r;
    byte_count_nxt  = byte_count_r;
    frame_count_nxt = frame_count_r;
    tick_count_nxt  = tick_count_r;
    exp_payload_nxt = exp_payload_r;
    exp_frames_nxt  = exp_frames_r;
    result          = '0;
    result.status   = rfc_pkg::ST_IDLE;

    if (item.operation == rfc_pkg::OP_START) begin
      exp_payload_nxt = len_clamped;
      exp_frames_nxt  = cnt_clamped;
      frame_count_nxt = '0;
      crc_nxt         = rfc_pkg::CRC_INIT;
      byte_count_nxt  = '0;
      tick_count_nxt  = '0;
      receiving_nxt   = 1'b1;
      result.status   = rfc_pkg::ST_RECEIVING;
    end else if (receiving_r) begin
      unique case (item.operation)
        rfc_pkg::OP_TICK: begin
          result.device_index = frame_count_r;
          tick_count_nxt      = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            receiving_nxt = 1'b0;
            result.status = rfc_pkg::ST_TIMEOUT;
          end else begin
            result.status = rfc_pkg::ST_RECEIVING;
          end
        end
        rfc_pkg::OP_BYTE: begin
          result.device_index = frame_count_r;
          result.byte_index   = byte_count_r;
          result.rx_byte_out  = item.rx_byte;
          result.is_payload   = (byte_count_r >= 8'(rfc_pkg::HEADER_BYTES)) &&
                                (byte_count_r < payload_end);
          result.status       = rfc_pkg::ST_RECEIVING;
          crc_nxt             = crc_after;
          byte_count_nxt      = byte_count_inc;
          if (byte_count_inc >= frame_size) begin
            // Frame complete: a good frame leaves a zero residue.
            if (crc_after != 16'h0000) begin
              result.status = rfc_pkg::ST_CRC_ERR;
              receiving_nxt = 1'b0;
            end else if (frame_next >= exp_frames_r) begin
              result.status = rfc_pkg::ST_ALL_OK;
              receiving_nxt = 1'b0;
            end else begin
              result.status   = rfc_pkg::ST_FRAME_OK;
              frame_count_nxt = frame_next[5:0];
              crc_nxt         = rfc_pkg::CRC_INIT;
              byte_count_nxt  = '0;
              tick_count_nxt  = '0;
            end
          end
        end
        default: begin
          result.status = rfc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r   <= 1'b0;
      crc_r         <= rfc_pkg::CRC_INIT;
      byte_count_r  <= '0;
      frame_count_r <= '0;
      tick_count_r  <= '0;
      exp_payload_r <= 8'd1;
      exp_frames_r  <= 7'd1;
    end else if (accept) begin
      receiving_r   <= receiving_nxt;
      crc_r         <= crc_nxt;
      byte_count_r  <= byte_count_nxt;
      frame_count_r <= frame_count_nxt;
      tick_count_r  <= tick_count_nxt;
      exp_payload_r <= exp_payload_nxt;
      exp_frames_r  <= exp_frames_nxt;
    end
  end

endmodule

>>> hw/rtl/rfc_out_reg.sv
// Result register with stream handshake for the response frame checker.
// Depends on rfc_pkg for the result type.
module rfc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rfc_pkg::rfc_result_t result_in,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rfc_pkg::rfc_result_t result_out
);

  logic                 valid_r;
  rfc_pkg::rfc_result_t data_r;

  // A new result may enter when the slot is empty or drains this cycle.
  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign result_out = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

endmodule

>>> hw/rtl/response_frame_checker.sv
// Response frame checker: top level. The result of an accepted input item is
// registered in the output register; one item is accepted
// every cycle while the result side keeps up, set by the single result register.
// Reset (rst_n low, synchronous) returns the receiver to idle with a timeout
// limit of 500 ticks and leaves the result register empty.
// Uses rfc_pkg, rfc_core and rfc_out_reg.
module response_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_byte[7:0], data_length[15:8],
                                  // num_devices[22:16], zero[23]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // device_index[5:0], byte_index[13:6],
                                  // rx_byte_out[21:14], is_payload[22], zero[23]
  output logic [2:0]  out_tuser,  // status[2:0]
  // Configuration: timeout limit in ticks per frame.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic                 accept;
  logic                 can_load;
  logic [15:0]          timeout_r;
  rfc_pkg::rfc_item_t   item;
  rfc_pkg::rfc_result_t core_result;
  rfc_pkg::rfc_result_t held_result;

  // Always ready; user writes the timeout register only while idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rfc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_data;
    end
  end

  // Every accepted item produces exactly one result, so the input is
  // accepted whenever the result register has room for it.
  assign in_tready = can_load;
  assign accept    = in_tvalid && in_tready;

  assign item.operation   = in_tuser;
  assign item.rx_byte     = in_tdata[7:0];
  assign item.data_length = in_tdata[15:8];
  assign item.num_devices = in_tdata[22:16];

  // Receive state, CRC check and result computation.
  rfc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .item          (item),
    .timeout_ticks (timeout_r),
    .result        (core_result)
  );

  // Output register that decouples the two sides of the stream.
  rfc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result_in  (core_result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result_out (held_result)
  );

  assign out_tuser = held_result.status;
  assign out_tdata = {1'b0, held_result.is_payload, held_result.rx_byte_out,
                      held_result.byte_index, held_result.device_index};

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the response frame checker: directed cases and
// random response chains, with results predicted per item and checked in order.
// Depends on rfc_pkg and on response_frame_checker.
module testbench;

  // Operation code that the block defines no action for.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  // Which frame of a chain gets a flipped bit.
  localparam int NO_ERROR  = -1;
  localparam int ANY_FRAME = -2;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Idle rates of both sides, in percent per cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_counted = 0;

  // Predicted copy of the receiver state and of the timeout register.
  logic        rx_active = 1'b0;
  logic [15:0] crc_acc = rfc_pkg::CRC_INIT;
  logic [7:0]  frame_pos = '0;
  logic [6:0]  frame_idx = '0;
  logic [15:0] tick_cnt = '0;
  logic [7:0]  payload_len = 8'd1;
  logic [6:0]  frames_total = 7'd1;
  logic [15:0] timeout_limit = rfc_pkg::TIMEOUT_RESET;

  rfc_pkg::rfc_result_t frame_results_due[$];

  response_frame_checker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit", $time);
      $display("status: fail");
      $finish;
    end
  end

  // CRC-16/MODBUS over one byte, worked bit by bit from the LSB.
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ rfc_pkg::CRC_POLY_REFL;
      end
    end
    return c;
  endfunction

  function automatic void open_frame();
    crc_acc = rfc_pkg::CRC_INIT;
    frame_pos = '0;
    tick_cnt = '0;
  endfunction

  // Advances the predicted state by one accepted item and returns its result.
  function automatic rfc_pkg::rfc_result_t next_frame_result(input logic [1:0] op,
                                                             input logic [7:0] rx,
                                                             input logic [7:0] len,
                                                             input logic [6:0] cnt);
    rfc_pkg::rfc_result_t r;
    int unsigned frame_size;
    r = '0;
    if (op == rfc_pkg::OP_START) begin
      // Out-of-range lengths and counts are pulled to the nearest legal value.
      payload_len = (len == 0) ? 8'd1 :
                    (len > rfc_pkg::MAX_PAYLOAD) ? 8'(rfc_pkg::MAX_PAYLOAD) : len;
      frames_total = (cnt == 0) ? 7'd1 :
                     (cnt > rfc_pkg::MAX_DEVICES) ? 7'(rfc_pkg::MAX_DEVICES) : cnt;
      frame_idx = '0;
      open_frame();
      rx_active = 1'b1;
      r.status = rfc_pkg::ST_RECEIVING;
    end else if (!rx_active || op == OP_UNKNOWN) begin
      r.status = rfc_pkg::ST_IDLE;
    end else if (op == rfc_pkg::OP_TICK) begin
      r.device_index = frame_idx[5:0];
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= timeout_limit) begin
        rx_active = 1'b0;
        r.status = rfc_pkg::ST_TIMEOUT;
      end else begin
        r.status = rfc_pkg::ST_RECEIVING;
      end
    end else begin
      frame_size = rfc_pkg::HEADER_BYTES + payload_len + rfc_pkg::CRC_BYTES;
      r.device_index = frame_idx[5:0];
      r.byte_index = frame_pos;
      r.rx_byte_out = rx;
      r.is_payload = (frame_pos >= rfc_pkg::HEADER_BYTES) &&
                     (frame_pos < rfc_pkg::HEADER_BYTES + payload_len);
      r.status = rfc_pkg::ST_RECEIVING;
      crc_acc = modbus_crc_byte(crc_acc, rx);
      frame_pos = frame_pos + 8'd1;
      if (frame_pos >= frame_size) begin
        // The CRC bytes themselves are fed too, so a clean frame ends at zero.
        if (crc_acc != 16'h0000) begin
          r.status = rfc_pkg::ST_CRC_ERR;
          rx_active = 1'b0;
        end else if (frame_idx + 1 >= frames_total) begin
          r.status = rfc_pkg::ST_ALL_OK;
          rx_active = 1'b0;
        end else begin
          r.status = rfc_pkg::ST_FRAME_OK;
          frame_idx = frame_idx + 7'd1;
          open_frame();
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result side: checks each accepted result and stalls at random.
  always @(posedge clk) begin : check_results
    rfc_pkg::rfc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d data 0x%h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = frame_results_due.pop_front();
        compare_field("status", want.status, out_tuser);
        compare_field("device_index", want.device_index, out_tdata[5:0]);
        compare_field("byte_index", want.byte_index, out_tdata[13:6]);
        compare_field("rx_byte_out", want.rx_byte_out, out_tdata[21:14]);
        compare_field("is_payload", want.is_payload, out_tdata[22]);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one item. Valid stays high from one item to the next unless the
  // sender idles, so it never gets two assignments in one step.
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                           input logic [7:0] len, input logic [6:0] cnt);
    rfc_pkg::rfc_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, cnt, len, rx};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    r = next_frame_result(op, rx, len, cnt);
    frame_results_due = {frame_results_due, r};
    if (r.status != rfc_pkg::ST_IDLE) begin
      items_counted++;
    end
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout_limit(input logic [15:0] ticks);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_limit = ticks;
  endtask

  // One start and its chain of frames with correct CRCs. Ticks come between
  // bytes at tick_pct, one frame may get a flipped bit, and the chain can be
  // cut short after cut_after bytes (0 keeps it whole). It stops as soon as
  // the receiver goes idle.
  task automatic send_response_chain(input logic [7:0] len, input logic [6:0] cnt,
                                     input int unsigned tick_pct, input int bad_frame,
                                     input int unsigned cut_after);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          err_frame;
    int unsigned sent;
    send_item(rfc_pkg::OP_START, 8'($urandom), len, cnt);
    err_frame = (bad_frame == ANY_FRAME) ? $urandom_range(frames_total - 1) : bad_frame;
    sent = 0;
    for (int f = 0; f < frames_total; f++) begin
      frame_bytes.delete();
      crc = rfc_pkg::CRC_INIT;
      for (int k = 0; k < rfc_pkg::HEADER_BYTES + payload_len; k++) begin
        b = 8'($urandom);
        frame_bytes = {frame_bytes, b};
        crc = modbus_crc_byte(crc, b);
      end
      frame_bytes = {frame_bytes, crc[7:0], crc[15:8]};
      if (f == err_frame) begin
        frame_bytes[$urandom_range(frame_bytes.size() - 1)] ^= 8'(1 << $urandom_range(7));
      end
      foreach (frame_bytes[k]) begin
        while ($urandom_range(99) < tick_pct) begin
          send_item(rfc_pkg::OP_TICK, 8'($urandom), 8'($urandom), 7'($urandom));
          if (!rx_active) return;
        end
        if ($urandom_range(99) < 2) begin
          send_item(OP_UNKNOWN, 8'($urandom), 8'($urandom), 7'($urandom));
        end
        send_item(rfc_pkg::OP_BYTE, frame_bytes[k], 8'($urandom), 7'($urandom));
        sent++;
        if (!rx_active || sent == cut_after) return;
      end
    end
  endtask

  // Mostly short payloads; now and then the largest or an out-of-range value.
  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 8'($urandom_range(1, 8));
    if (r < 90) return 8'($urandom_range(9, 127));
    if (r < 95) return 8'(rfc_pkg::MAX_PAYLOAD);
    return ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(129, 255));
  endfunction

  // Long chains only go with short payloads to keep the run bounded.
  function automatic logic [6:0] pick_count(input logic [7:0] len);
    int unsigned r;
    r = $urandom_range(99);
    if (len == 0 || len > 16) return 7'($urandom_range(0, 2));
    if (r < 85) return 7'($urandom_range(1, 4));
    if (r < 90) return 7'd0;
    if (r < 97 || len > 2) return 7'($urandom_range(5, 12));
    return 7'($urandom_range(13, 127));
  endfunction

  // The timeout register must come out of reset at 500 ticks.
  task automatic test_reset_timeout();
    send_item(rfc_pkg::OP_START, 8'h00, 8'd4, 7'd1);
    repeat (rfc_pkg::TIMEOUT_RESET) begin
      send_item(rfc_pkg::OP_TICK, 8'h00, 8'h00, 7'h00);
    end
  endtask

  // Bytes, ticks and the unused code are ignored while idle.
  task automatic test_idle_ignored();
    send_item(rfc_pkg::OP_BYTE, 8'hFF, 8'hFF, 7'h7F);
    send_item(rfc_pkg::OP_TICK, 8'h00, 8'h00, 7'h00);
    send_item(OP_UNKNOWN, 8'hA5, 8'h80, 7'h40);
  endtask

  // A start with both fields above range, then activity mid-frame, then a
  // restart with the length below range: one good frame, then the last one.
  task automatic test_restart_mid_frame();
    send_item(rfc_pkg::OP_START, 8'hFF, 8'hFF, 7'h7F);
    send_item(OP_UNKNOWN, 8'h5A, 8'h01, 7'h01);
    send_item(rfc_pkg::OP_TICK, 8'h00, 8'h00, 7'h00);
    send_item(rfc_pkg::OP_BYTE, 8'h00, 8'h00, 7'h00);
    send_response_chain(8'd0, 7'd2, 0, NO_ERROR, 0);
  endtask

  // A count of zero taken as one, and a corrupted frame ending the receive.
  task automatic test_crc_error();
    send_response_chain(8'd1, 7'd0, 0, 0, 0);
  endtask

  // A zero limit times out on the very first tick.
  task automatic test_zero_timeout();
    write_timeout_limit(16'd0);
    send_item(rfc_pkg::OP_START, 8'h00, 8'd1, 7'd1);
    send_item(rfc_pkg::OP_TICK, 8'h00, 8'h00, 7'h00);
  endtask

  // Random traffic under one idle and stall setting and one timeout limit. Most of it is
  // whole chains; the rest is corrupted, cut short, tick-heavy or lone items.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [15:0] limit);
    int unsigned stop_at;
    int unsigned kind;
    logic [7:0]  len;
    write_timeout_limit(limit);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_counted + ITEMS_PER_PHASE;
    while (items_counted < stop_at) begin
      kind = $urandom_range(99);
      len = pick_length();
      if (kind < 68) begin
        send_response_chain(len, pick_count(len), 4, NO_ERROR, 0);
      end else if (kind < 78) begin
        send_response_chain(len, pick_count(len), 4, ANY_FRAME, 0);
      end else if (kind < 86) begin
        send_response_chain(len, pick_count(len), 4, NO_ERROR, $urandom_range(1, 12));
      end else if (kind < 92) begin
        send_response_chain(len, pick_count(len), 40, NO_ERROR, 0);
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_timeout();
    test_idle_ignored();
    test_restart_mid_frame();
    test_crc_error();
    test_zero_timeout();
    test_random_traffic(0, 0, 16'hFFFF);
    test_random_traffic(63, 0, 16'($urandom_range(30, 400)));
    test_random_traffic(0, 63, 16'd6);
    test_random_traffic(22, 22, 16'd1);
    wait_results_drained();
    // Room for any stray result after the last expected one.
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> response_frame_checker.f
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_core.sv
hw/rtl/rfc_out_reg.sv
hw/rtl/response_frame_checker.sv
tb/sv/testbench.sv
